[design/row_event_column_splitter_assert.svh]
// assertion macros shared by the checker
`ifndef ROW_EVENT_COLUMN_SPLITTER_ASSERT_SVH
`define ROW_EVENT_COLUMN_SPLITTER_ASSERT_SVH
// same-cycle implication
`define RECS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("row event splitter check failed");
// next-cycle implication
`define RECS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("row event splitter check failed");
`endif

[design/recs_pkg.sv]
`timescale 1ns / 1ps
package recs_pkg;

   typedef enum logic [14:0] {
      PH_CNT    = 15'h0001,
      PH_TYPES  = 15'h0002,
      PH_MLEN   = 15'h0004,
      PH_META   = 15'h0008,
      PH_SKIP   = 15'h0010,
      PH_PACKED = 15'h0020,
      PH_USED   = 15'h0040,
      PH_USEDA  = 15'h0080,
      PH_NULL   = 15'h0100,
      PH_PREFIX = 15'h0200,
      PH_DATA   = 15'h0400,
      PH_IDLE   = 15'h0800,
      PH_ERR1   = 15'h1000,
      PH_ERR2   = 15'h2000,
      PH_ERR3   = 15'h4000
   } phase_type;

   localparam logic [1:0] BK_HEADER = 2'd0;
   localparam logic [1:0] BK_DATA   = 2'd1;
   localparam logic [1:0] BK_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ERR_COLUMNS     = 2'd2;
   localparam logic [1:0] ERR_META        = 2'd3;

   localparam logic [1:0] KIND_UPDATE = 2'd1;

   localparam logic [7:0] TY_TINY     = 8'd1;
   localparam logic [7:0] TY_SHORT    = 8'd2;
   localparam logic [7:0] TY_LONG     = 8'd3;
   localparam logic [7:0] TY_FLOAT    = 8'd4;
   localparam logic [7:0] TY_DOUBLE   = 8'd5;
   localparam logic [7:0] TY_STAMP    = 8'd7;
   localparam logic [7:0] TY_LONGLONG = 8'd8;
   localparam logic [7:0] TY_INT24    = 8'd9;
   localparam logic [7:0] TY_DATE     = 8'd10;
   localparam logic [7:0] TY_TIME     = 8'd11;
   localparam logic [7:0] TY_DATETIME = 8'd12;
   localparam logic [7:0] TY_YEAR     = 8'd13;
   localparam logic [7:0] TY_VARCHAR  = 8'd15;
   localparam logic [7:0] TY_BIT      = 8'd16;
   localparam logic [7:0] TY_DECIMAL  = 8'd246;
   localparam logic [7:0] TY_BLOB     = 8'd252;
   localparam logic [7:0] TY_VARSTR   = 8'd253;
   localparam logic [7:0] TY_STRING   = 8'd254;
   localparam logic [7:0] TY_GEOMETRY = 8'd255;

   localparam logic [7:0] PK_ALL_ONES = 8'd251;
   localparam logic [7:0] PK_TWO      = 8'd252;
   localparam logic [7:0] PK_THREE    = 8'd253;
   localparam logic [7:0] STR_FIX     = 8'h30;

   localparam logic [2:0] DIGIT_BYTES [0:8] = '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2,
                                               3'd3, 3'd3, 3'd4, 3'd4};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_event;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [1:0]  byte_kind;
      logic [5:0]  column_number;
      logic        column_first;
      logic        column_last;
      logic        row_last;
      logic        after_image;
      logic [31:0] field_length;
      logic [1:0]  error_code;
   } rsp_payload_type;

   typedef struct packed {
      logic step;
      logic eval;
      logic put;
   } recs_cmd_type;

   typedef struct packed {
      logic seek_req;
      logic seek_more;
      logic out_free;
   } recs_status_type;

   function automatic logic [1:0] meta_len_of(input logic [7:0] t);
      logic [1:0] r;
      r = 2'd0;
      if (t == TY_FLOAT || t == TY_DOUBLE || t == TY_BLOB || t == TY_GEOMETRY) r = 2'd1;
      if (t == TY_VARCHAR || t == TY_BIT || t == TY_DECIMAL || t == TY_VARSTR ||
          t == TY_STRING) r = 2'd2;
      return r;
   endfunction

   function automatic logic [3:0] fixed_len_of(input logic [7:0] t);
      logic [3:0] r;
      r = 4'd0;
      if (t == TY_TINY || t == TY_YEAR) r = 4'd1;
      if (t == TY_SHORT) r = 4'd2;
      if (t == TY_INT24 || t == TY_DATE || t == TY_TIME) r = 4'd3;
      if (t == TY_LONG || t == TY_FLOAT || t == TY_STAMP) r = 4'd4;
      if (t == TY_DOUBLE || t == TY_LONGLONG || t == TY_DATETIME) r = 4'd8;
      return r;
   endfunction

   function automatic logic supported(input logic [7:0] t);
      return fixed_len_of(t) != 4'd0 || meta_len_of(t) == 2'd2 ||
             t == TY_BLOB || t == TY_GEOMETRY;
   endfunction

   function automatic logic [7:0] prefix_len(input logic [7:0] t, input logic [7:0] m0,
                                             input logic [7:0] m1);
      logic [7:0] r;
      r = 8'd0;
      if (t == TY_VARCHAR) r = (m1 == 8'd0) ? 8'd1 : 8'd2;
      if (t == TY_BLOB || t == TY_GEOMETRY) r = m0;
      if (t == TY_VARSTR) r = m1;
      // max length above 255 unless both fix bits are set
      if (t == TY_STRING) r = ((m0 & STR_FIX) == STR_FIX) ? 8'd1 : 8'd2;
      return r;
   endfunction

   // x / 9 by reciprocal, exact for 8-bit x
   function automatic logic [4:0] div9(input logic [7:0] x);
      logic [13:0] p;
      p = 14'(x) * 14'd57;
      return p[13:9];
   endfunction

   function automatic logic [6:0] dec_bytes(input logic [7:0] x);
      logic [4:0] q;
      logic [7:0] r;
      q = div9(x);
      r = x - 8'(q) * 8'd9;
      return {q, 2'b00} + 7'(DIGIT_BYTES[r[3:0]]);
   endfunction

   function automatic logic [8:0] plain_len(input logic [7:0] t, input logic [7:0] m0,
                                            input logic [7:0] m1);
      logic [7:0] intg;
      logic [8:0] r;
      intg = (m0 > m1) ? (m0 - m1) : 8'd0;
      r = 9'(fixed_len_of(t));
      if (t == TY_BIT) r = 9'(m1) + ((m0 != 8'd0) ? 9'd1 : 9'd0);
      if (t == TY_DECIMAL) r = 9'(dec_bytes(intg)) + 9'(dec_bytes(m1));
      return r;
   endfunction

   function automatic logic [31:0] acc_byte(input logic [31:0] acc, input logic [31:0] k,
                                            input logic [7:0] b);
      logic [31:0] r;
      r = acc;
      if (k < 32'd4) r = acc | ({24'd0, b} << {k[1:0], 3'b000});
      else if (b != 8'd0) r = '1;
      return r;
   endfunction

endpackage

[design/recs_datapath.sv]
`timescale 1ns / 1ps
module recs_datapath #(
   parameter int MAX_COLUMNS    = 64,
   parameter int MAX_META_BYTES = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  recs_pkg::recs_cmd_type    cmd,
   output recs_pkg::recs_status_type status,
   input  recs_pkg::req_payload_type req_payload,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_write_data,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output recs_pkg::rsp_payload_type rsp_payload
);
   import recs_pkg::*;

   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int MW = $clog2(MAX_META_BYTES);
   localparam logic [31:0] MAX_COL_W  = 32'(MAX_COLUMNS);
   localparam logic [31:0] MAX_META_W = 32'(MAX_META_BYTES);

   logic [7:0] type_mem [MAX_COLUMNS];
   logic [7:0] meta_mem [MAX_META_BYTES];
   logic [7:0] type_rd_ff, meta_rd0_ff, meta_rd1_ff;

   phase_type       phase_ff, phase_in;
   logic [6:0]      col_total_ff, col_total_in;
   logic [7:0]      meta_total_ff, meta_total_in;
   logic [63:0]     used_b_ff, used_b_in, used_a_ff, used_a_in, null_ff, null_in;
   logic [6:0]      cc_ff, cc_in;
   logic [7:0]      moff_ff, moff_in;
   logic [31:0]     bc_ff, bc_in, acc_ff, acc_in;
   logic            tog_ff, tog_in;
   logic [1:0]      kind_ff;
   rsp_payload_type pend_ff, pend_in, out_ff, out_in;
   logic            eoe_ff, eoe_in, outv_ff, outv_in;

   logic            type_we, meta_we;
   logic [7:0]      b, m0, m1, pfx;
   logic [8:0]      pln;
   logic [3:0]      un, tot_p;
   logic [31:0]     bc_inc, fin_v;
   logic            fin_req, bad, adv, seek_req, seek_more;
   logic [63:0]     map;
   rsp_payload_type res;

   assign b = req_payload.in_byte;
   assign m0 = ({1'b0, moff_ff} < {1'b0, meta_total_ff}) ? meta_rd0_ff : 8'd0;
   assign m1 = ({1'b0, moff_ff} + 9'd1 < {1'b0, meta_total_ff}) ? meta_rd1_ff : 8'd0;
   assign pfx = prefix_len(type_rd_ff, m0, m1);
   assign pln = plain_len(type_rd_ff, m0, m1);
   assign un = 4'(({1'b0, col_total_ff} + 8'd7) >> 3);
   assign map = tog_ff ? used_a_ff : used_b_ff;

   always_comb begin
      phase_in = phase_ff;
      col_total_in = col_total_ff;
      meta_total_in = meta_total_ff;
      used_b_in = used_b_ff;
      used_a_in = used_a_ff;
      null_in = null_ff;
      cc_in = cc_ff;
      moff_in = moff_ff;
      bc_in = bc_ff;
      acc_in = acc_ff;
      tog_in = tog_ff;
      pend_in = pend_ff;
      eoe_in = eoe_ff;
      out_in = out_ff;
      outv_in = outv_ff && rsp_stall;
      type_we = 1'b0;
      meta_we = 1'b0;
      fin_req = 1'b0;
      fin_v = '0;
      bad = 1'b0;
      adv = 1'b0;
      seek_req = 1'b0;
      seek_more = 1'b0;
      tot_p = 4'd0;
      bc_inc = bc_ff + 32'd1;
      res = '0;
      res.out_byte = b;

      if (cmd.step) begin
         case (phase_ff)
            PH_CNT: begin
               acc_in = acc_byte(acc_ff, bc_ff, b);
               bc_in = bc_inc;
               if (bc_inc >= 32'd4) begin
                  if (acc_in > MAX_COL_W) begin
                     phase_in = PH_ERR2;
                     bad = 1'b1;
                  end else begin
                     col_total_in = acc_in[6:0];
                     bc_in = '0;
                     acc_in = '0;
                     phase_in = (col_total_in != 7'd0) ? PH_TYPES : PH_MLEN;
                  end
               end
            end
            PH_TYPES: begin
               type_we = bc_ff < MAX_COL_W;
               bc_in = bc_inc;
               if (bc_inc >= 32'(col_total_ff)) begin
                  bc_in = '0;
                  acc_in = '0;
                  phase_in = PH_MLEN;
               end
            end
            PH_MLEN: begin
               acc_in = acc_byte(acc_ff, bc_ff, b);
               bc_in = bc_inc;
               if (bc_inc >= 32'd4) begin
                  if (acc_in > MAX_META_W) begin
                     phase_in = PH_ERR3;
                     bad = 1'b1;
                  end else begin
                     meta_total_in = acc_in[7:0];
                     bc_in = '0;
                     phase_in = (acc_in[7:0] != 8'd0) ? PH_META : PH_SKIP;
                  end
               end
            end
            PH_META: begin
               meta_we = bc_ff < MAX_META_W;
               bc_in = bc_inc;
               if (bc_inc >= 32'(meta_total_ff)) begin
                  bc_in = '0;
                  phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               bc_in = bc_inc;
               if (bc_inc >= 32'd8) begin
                  bc_in = '0;
                  acc_in = '0;
                  phase_in = PH_PACKED;
               end
            end
            PH_PACKED: begin
               if (bc_ff == 32'd0) begin
                  if (b < PK_ALL_ONES) begin
                     fin_req = 1'b1;
                     fin_v = 32'(b);
                  end else if (b == PK_ALL_ONES) begin
                     fin_req = 1'b1;
                     fin_v = '1;
                  end else begin
                     tot_p = (b == PK_TWO) ? 4'd2 : ((b == PK_THREE) ? 4'd3 : 4'd8);
                     acc_in = '0;
                     bc_in = {20'd0, tot_p, 8'd1};
                  end
               end else begin
                  tot_p = bc_ff[11:8];
                  acc_in = acc_byte(acc_ff, 32'(bc_ff[7:0] - 8'd1), b);
                  bc_in = bc_inc;
                  if ((bc_inc[7:0] - 8'd1) >= {4'd0, tot_p}) begin
                     fin_req = 1'b1;
                     fin_v = acc_in;
                  end
               end
            end
            PH_USED, PH_USEDA: begin
               if (bc_ff < 32'd8) begin
                  if (phase_ff == PH_USED)
                     used_b_in = used_b_ff | ({56'd0, b} << {bc_ff[2:0], 3'b000});
                  else
                     used_a_in = used_a_ff | ({56'd0, b} << {bc_ff[2:0], 3'b000});
               end
               bc_in = bc_inc;
               if (bc_inc >= 32'(un)) begin
                  bc_in = '0;
                  if (phase_ff == PH_USED && kind_ff == KIND_UPDATE) begin
                     phase_in = PH_USEDA;
                  end else begin
                     phase_in = (col_total_ff != 7'd0) ? PH_NULL : PH_IDLE;
                     null_in = '0;
                  end
               end
            end
            PH_NULL: begin
               res.after_image = tog_ff;
               if (bc_ff < 32'd8)
                  null_in = null_ff | ({56'd0, b} << {bc_ff[2:0], 3'b000});
               bc_in = bc_inc;
               if (bc_inc >= 32'(un)) begin
                  cc_in = '0;
                  moff_in = '0;
                  seek_req = 1'b1;
               end
            end
            PH_PREFIX: begin
               res.after_image = tog_ff;
               res.column_number = cc_ff[5:0];
               acc_in = acc_byte(acc_ff, bc_ff, b);
               bc_in = bc_inc;
               if (bc_inc >= 32'(pfx)) begin
                  bc_in = '0;
                  if (acc_in != 32'd0) begin
                     phase_in = PH_DATA;
                  end else begin
                     adv = 1'b1;
                     seek_req = 1'b1;
                  end
               end
            end
            PH_DATA: begin
               res.byte_kind = BK_DATA;
               res.after_image = tog_ff;
               res.column_number = cc_ff[5:0];
               res.field_length = acc_ff;
               res.column_first = bc_ff == 32'd0;
               bc_in = bc_inc;
               if (bc_inc >= acc_ff) begin
                  res.column_last = 1'b1;
                  adv = 1'b1;
                  seek_req = 1'b1;
               end
            end
            PH_ERR1, PH_ERR2, PH_ERR3: bad = 1'b1;
            default: ;
         endcase

         if (fin_req) begin
            if (fin_v > 32'(col_total_ff) || fin_v > MAX_COL_W) begin
               phase_in = PH_ERR2;
               bad = 1'b1;
            end else begin
               col_total_in = fin_v[6:0];
               used_b_in = '0;
               used_a_in = '0;
               bc_in = '0;
               phase_in = (fin_v != 32'd0) ? PH_USED : PH_IDLE;
            end
         end

         if (bad) begin
            res = '0;
            res.out_byte = b;
            res.byte_kind = BK_ERROR;
            if (phase_in == PH_ERR1) res.error_code = ERR_UNSUPPORTED;
            else if (phase_in == PH_ERR2) res.error_code = ERR_COLUMNS;
            else res.error_code = ERR_META;
         end
         pend_in = res;
         eoe_in = req_payload.end_of_event;
      end

      // one column of the seek per evaluation
      if (cmd.eval) begin
         if (cc_ff >= col_total_ff) begin
            if (kind_ff == KIND_UPDATE) tog_in = !tog_ff;
            phase_in = (col_total_ff != 7'd0) ? PH_NULL : PH_IDLE;
            null_in = '0;
            bc_in = '0;
            pend_in.row_last = 1'b1;
         end else if (!map[cc_ff[5:0]] || null_ff[cc_ff[5:0]]) begin
            adv = 1'b1;
            seek_more = 1'b1;
         end else if (!supported(type_rd_ff)) begin
            phase_in = PH_ERR1;
         end else begin
            bc_in = '0;
            if (pfx != 8'd0) begin
               phase_in = PH_PREFIX;
               acc_in = '0;
            end else if (pln != 9'd0) begin
               phase_in = PH_DATA;
               acc_in = 32'(pln);
            end else begin
               adv = 1'b1;
               seek_more = 1'b1;
            end
         end
      end

      if (adv) begin
         moff_in = moff_ff + 8'(meta_len_of(type_rd_ff));
         cc_in = cc_ff + 7'd1;
      end

      if (cmd.put) begin
         out_in = pend_ff;
         outv_in = 1'b1;
         if (eoe_ff) begin
            phase_in = PH_CNT;
            col_total_in = '0;
            meta_total_in = '0;
            used_b_in = '0;
            used_a_in = '0;
            null_in = '0;
            cc_in = '0;
            moff_in = '0;
            bc_in = '0;
            acc_in = '0;
            tog_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CNT;
         col_total_ff <= '0;
         meta_total_ff <= '0;
         used_b_ff <= '0;
         used_a_ff <= '0;
         null_ff <= '0;
         cc_ff <= '0;
         moff_ff <= '0;
         bc_ff <= '0;
         acc_ff <= '0;
         tog_ff <= 1'b0;
         eoe_ff <= 1'b0;
         outv_ff <= 1'b0;
         kind_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         col_total_ff <= col_total_in;
         meta_total_ff <= meta_total_in;
         used_b_ff <= used_b_in;
         used_a_ff <= used_a_in;
         null_ff <= null_in;
         cc_ff <= cc_in;
         moff_ff <= moff_in;
         bc_ff <= bc_in;
         acc_ff <= acc_in;
         tog_ff <= tog_in;
         eoe_ff <= eoe_in;
         outv_ff <= outv_in;
         if (csr_write_enable) kind_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   // stores, read every cycle at the current column and meta position
   always_ff @(posedge clock) begin
      if (type_we) type_mem[bc_ff[CW-1:0]] <= b;
      if (meta_we) meta_mem[bc_ff[MW-1:0]] <= b;
      type_rd_ff <= type_mem[cc_ff[CW-1:0]];
      meta_rd0_ff <= meta_mem[moff_ff[MW-1:0]];
      meta_rd1_ff <= meta_mem[MW'(moff_ff + 8'd1)];
   end

   assign status.seek_req = seek_req;
   assign status.seek_more = seek_more;
   assign status.out_free = !outv_ff || !rsp_stall;
   assign rsp_valid = outv_ff;
   assign rsp_payload = out_ff;

endmodule

[design/recs_ctrl.sv]
`timescale 1ns / 1ps
module recs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  recs_pkg::recs_status_type status,
   output recs_pkg::recs_cmd_type    cmd
);
   import recs_pkg::*;

   typedef enum logic [3:0] {
      ST_WAIT  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_PUT   = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_WAIT: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = status.seek_req ? ST_FETCH : ST_PUT;
            end
         end
         // store read data settles for the new column
         ST_FETCH: state_in = ST_EVAL;
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.seek_more ? ST_FETCH : ST_PUT;
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.put = 1'b1;
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_WAIT;

endmodule

[design/row_event_column_splitter.sv]
`timescale 1ns / 1ps
// Row event column splitter: takes a row event body one byte per beat on the
// req_ channel and returns one tagged beat per input byte on the rsp_ channel.
// csr_write_data sets the event kind (write, update, delete); the user must
// write it only while idle, as the block itself does not enforce this.
// A byte that needs no column search is accepted and parsed, then its result
// is moved into the output register. When a byte ends a column or the null
// bitmap, the search for the next column first walks the stored column types
// one column at a time, a store read and then an evaluation for each, as the
// type and meta stores have registered reads. A new byte is taken only after
// the previous result is in the output register; if the receiver stalls, that
// register holds its beat and the next result waits, so input stalls too.
// Synchronous reset returns the parser to the column count of a new event
// and clears the event kind; the type and meta stores are not cleared.
// After a beat marked end_of_event the parser state returns to that point; the event kind is kept.
module row_event_column_splitter #(
   parameter int MAX_COLUMNS    = 64,
   parameter int MAX_META_BYTES = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  recs_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output recs_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_write_data
);
   import recs_pkg::*;

   recs_cmd_type    cmd;
   recs_status_type status;

   recs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   recs_datapath #(
      .MAX_COLUMNS    (MAX_COLUMNS),
      .MAX_META_BYTES (MAX_META_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload)
   );

endmodule

[design/recs_checker.sv]
`timescale 1ns / 1ps
`include "row_event_column_splitter_assert.svh"
module recs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input recs_pkg::rsp_payload_type rsp_payload
);
   import recs_pkg::*;

   `RECS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_payload))
   // one byte in flight at a time
   `RECS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   `RECS_ASSERT_NOW(a_error_clean, clock, reset, rsp_valid && rsp_payload.byte_kind == BK_ERROR,
      rsp_payload.error_code != ERR_NONE && rsp_payload.field_length == 32'd0 &&
      !rsp_payload.column_first && !rsp_payload.column_last && !rsp_payload.row_last)
   `RECS_ASSERT_NOW(a_marks_on_data, clock, reset,
      rsp_valid && (rsp_payload.column_first || rsp_payload.column_last),
      rsp_payload.byte_kind == BK_DATA && rsp_payload.field_length != 32'd0)

endmodule

bind row_event_column_splitter recs_checker u_recs_checker (.*);
